[rtl/oaht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-address hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int DEF_SLOTS         = 1024;
    localparam int DEF_PERTURB_SHIFT = 5;
    localparam int KEY_W             = 32;
    localparam int SLOT_W            = 10;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_NEW     = 3'd2,
        ST_UPDATED = 3'd3,
        ST_DELETED = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  hash_code;
        logic [KEY_W-1:0]  value;
    } in_word_t;

    typedef struct packed {
        status_t           status;
        logic [KEY_W-1:0]  value_out;
        logic [SLOT_W-1:0] slot;
    } out_word_t;

    // One table slot as held in the slot memory.
    typedef struct packed {
        logic [1:0]        tag;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  hash_code;
        logic [KEY_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
        logic clr_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic probe_done;
        logic clr_last;
        logic in_is_clear;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/oaht_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds without rd_en.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/oaht_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_datapath
// Probe registers, slot memory, fill count, result logic and output register.
// ----------------------------------------------------------------------------
module oaht_datapath
    import oaht_pkg::*;
#(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int PERTURB_SHIFT = DEF_PERTURB_SHIFT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int LIMIT    = SLOTS + 32;
    localparam int CNT_W    = $clog2(LIMIT);
    localparam int FILL_W   = IDX_W + 1;
    localparam int FILL_MAX = ((SLOTS - 1) * 2) / 3;

    in_word_t          req_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [KEY_W-1:0]  perturb_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [IDX_W-1:0]  tomb_reg;
    logic              have_tomb_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_entry;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t            rd_entry;

    logic [IDX_W-1:0]  i_next;
    logic              is_empty;
    logic              is_live;
    logic              is_tomb;
    logic              match;
    logic              last;
    logic              cand;
    logic              cand_empty;
    logic [IDX_W-1:0]  where_idx;
    logic              fill_full;
    out_word_t         res;
    logic              do_write;
    logic              fill_inc;

    // Slot memory.
    oaht_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);

    // Next probe index: i = 5i + 1 + perturb, kept to the index width.
    assign i_next = (i_reg << 2) + i_reg + IDX_W'(1) + perturb_reg[IDX_W-1:0];

    assign rd_en   = (cmd.start && (in_word.kind != KIND_CLEAR)) || cmd.step;
    assign rd_addr = cmd.start ? in_word.hash_code[IDX_W-1:0] : i_next;

    // Classification of the slot just read.
    assign is_empty = (rd_entry.tag == TAG_EMPTY);
    assign is_live  = (rd_entry.tag == TAG_LIVE);
    assign is_tomb  = !is_empty && !is_live;
    assign match    = is_live && (rd_entry.hash_code == req_reg.hash_code)
                      && (rd_entry.key == req_reg.key);
    assign last     = (n_reg == CNT_W'(LIMIT - 1));

    // Candidate slot for an insert when the probe ends without a match.
    assign cand       = is_empty || have_tomb_reg || is_tomb;
    assign cand_empty = is_empty && !have_tomb_reg;
    assign where_idx  = have_tomb_reg ? tomb_reg : i_reg;
    assign fill_full  = (fill_reg >= FILL_W'(FILL_MAX));

    // Result and write decision for the finishing cycle, and the slot write of a clearing sweep.
    always_comb
    begin
        res       = '{status: ST_ABSENT, value_out: '0, slot: '0};
        do_write  = 1'b0;
        fill_inc  = 1'b0;
        wr_entry  = '{tag: TAG_LIVE, key: req_reg.key, hash_code: req_reg.hash_code,
                      value: req_reg.value};
        wr_addr   = where_idx;
        unique case (req_reg.kind)
            KIND_LOOKUP:
            begin
                if (match)
                begin
                    res = '{status: ST_FOUND, value_out: rd_entry.value,
                            slot: SLOT_W'(32'(i_reg))};
                end
            end
            KIND_DELETE:
            begin
                if (match)
                begin
                    res          = '{status: ST_DELETED, value_out: '0,
                                     slot: SLOT_W'(32'(i_reg))};
                    do_write     = 1'b1;
                    wr_addr      = i_reg;
                    wr_entry     = rd_entry;
                    wr_entry.tag = TAG_TOMB;
                end
            end
            KIND_INSERT:
            begin
                if (match)
                begin
                    res            = '{status: ST_UPDATED, value_out: rd_entry.value,
                                       slot: SLOT_W'(32'(i_reg))};
                    do_write       = 1'b1;
                    wr_addr        = i_reg;
                    wr_entry       = rd_entry;
                    wr_entry.value = req_reg.value;
                end
                else if (!cand || (cand_empty && fill_full))
                begin
                    res = '{status: ST_FULL, value_out: '0, slot: '0};
                end
                else
                begin
                    res      = '{status: ST_NEW, value_out: '0,
                                 slot: SLOT_W'(32'(where_idx))};
                    do_write = 1'b1;
                    fill_inc = cand_empty;
                end
            end
            KIND_CLEAR:
            begin
                res = '{status: ST_DELETED, value_out: '0, slot: '0};
            end
            default:
            begin
                res = '{status: ST_ABSENT, value_out: '0, slot: '0};
            end
        endcase
        if (cmd.clr_wr)
        begin
            wr_addr  = clr_cnt_reg;
            wr_entry = '0;
        end
    end

    assign wr_en = cmd.clr_wr || (cmd.commit && do_write);

    // Probe state, counts and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= '0;
            i_reg         <= '0;
            perturb_reg   <= '0;
            n_reg         <= '0;
            tomb_reg      <= '0;
            have_tomb_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                req_reg       <= in_word;
                i_reg         <= in_word.hash_code[IDX_W-1:0];
                perturb_reg   <= in_word.hash_code;
                n_reg         <= '0;
                have_tomb_reg <= 1'b0;
                if (in_word.kind == KIND_CLEAR)
                begin
                    fill_reg <= '0;
                end
            end
            if (cmd.step)
            begin
                i_reg       <= i_next;
                perturb_reg <= perturb_reg >> PERTURB_SHIFT;
                n_reg       <= n_reg + CNT_W'(1);
                if (is_tomb && !have_tomb_reg)
                begin
                    tomb_reg      <= i_reg;
                    have_tomb_reg <= 1'b1;
                end
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.commit && fill_inc)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                out_word_reg  <= res;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.probe_done  = is_empty || match || last;
    assign stat.clr_last    = (clr_cnt_reg == IDX_W'(SLOTS - 1));
    assign stat.in_is_clear = (in_word.kind == KIND_CLEAR);
    assign stat.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A result is only written when the output register can take it.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit while output register busy");

    // The probe never advances past its end.
    a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !stat.probe_done)
        else $error("probe advanced after its end");

    // The fill count never passes the load bound.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(FILL_MAX))
        else $error("fill count above load bound");

endmodule

[rtl/oaht_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer for clearing sweeps, probing and result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    // Commands and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.in_is_clear ? S_CLEAR : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.probe_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_BOOT;
            in_stall_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

[rtl/open_address_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_table
// Key/value map with open addressing and perturbed probing.
// ----------------------------------------------------------------------------
//  Channel | Signals                      | Word
//  --------+------------------------------+---------------------------------
//  input   | in_valid, in_stall, in_word  | kind, key, hash_code, value
//  output  | out_valid, out_stall, out_word | status, value_out, slot
//
// A lookup, insert or delete reads one probed slot per cycle from the slot
// memory, then hands off its result once the output register is free.
// A clear writes one slot per cycle, then hands off its result in the same way.
// After reset a clearing pass over all SLOTS slots runs before the first word.
// A waiting result does not block the next word; a new result waits
// while the output register still holds a stalled one.
// ----------------------------------------------------------------------------
module open_address_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int PERTURB_SHIFT = DEF_PERTURB_SHIFT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller.
    oaht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    oaht_datapath #(
        .SLOTS         (SLOTS),
        .PERTURB_SHIFT (PERTURB_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
